### design/mmt_pkg.sv
`timescale 1ns / 1ps
// Shared types, constants and bit-search helpers for the multiset mex tracker.
// No dependencies.
package mmt_pkg;

  localparam int VALUE_BITS      = 10;
  localparam int MEX_BITS        = 11;
  localparam int WORD_BITS       = 32;
  localparam int WORD_SHIFT      = 5;
  localparam int MAX_SEARCH      = 1024;
  localparam int DEF_VALUE_RANGE = 1024;
  localparam int DEF_COUNT_BITS  = 16;

  localparam logic KIND_INSERT = 1'b0;
  localparam logic KIND_REMOVE = 1'b1;

  typedef struct packed {
    logic                  kind;
    logic [VALUE_BITS-1:0] value;
  } req_item_t;

  typedef struct packed {
    logic                accepted;
    logic                was_present;
    logic [MEX_BITS-1:0] mex_value;
  } rsp_item_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_UPD,
    ST_SRCH_A,
    ST_SRCH_B
  } state_t;

  // index of the lowest clear bit; 0 when none is clear
  function automatic logic [WORD_SHIFT-1:0] lowest_zero(input logic [WORD_BITS-1:0] x);
    logic [WORD_SHIFT-1:0] idx;
    idx = '0;
    for (int i = WORD_BITS - 1; i >= 0; i--) begin
      if (!x[i]) idx = WORD_SHIFT'(i);
    end
    return idx;
  endfunction

  // index of the lowest set bit; 0 when none is set
  function automatic logic [WORD_SHIFT-1:0] lowest_one(input logic [WORD_BITS-1:0] x);
    logic [WORD_SHIFT-1:0] idx;
    idx = '0;
    for (int i = WORD_BITS - 1; i >= 0; i--) begin
      if (x[i]) idx = WORD_SHIFT'(i);
    end
    return idx;
  endfunction

endpackage

### design/mmt_ram.sv
`timescale 1ns / 1ps
// Simple dual-port synchronous RAM: one write port, one read port,
// registered read data. No dependencies.
module mmt_ram #(
  parameter int DEPTH = 32,
  parameter int WIDTH = 32,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // read data holds until the next read
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

### design/multiset_mex_tracker.sv
`timescale 1ns / 1ps
// Multiset of bounded values with saturating counts and a mex query.
// Each request item inserts or removes one occurrence of a value; the response
// item tells whether the count changed, whether the value was present before,
// and the smallest absent value at or above mex_start (the range size when
// none). Before the next item can be accepted, an item passes through ST_UPD
// and ST_SRCH_A when the word of 32 presence bits holding mex_start settles the
// result (an absent value at or above mex_start, mex_start past the range, or
// no word above it with an absent value), and also through ST_SRCH_B when the
// first non-full word above must be read; the result also waits on rsp_ready.
// The response turns valid in the same cycle that req_ready rises again. The
// presence-word memory has a single read port, which is read for the update,
// for the start word and for the first non-full word, in that order.
// Counts and presence words live in RAMs; per-word valid bits clear the bitmap
// at reset, so no clearing pass is needed. Depends on mmt_pkg and mmt_ram.
module multiset_mex_tracker import mmt_pkg::*; #(
  parameter int VALUE_RANGE = DEF_VALUE_RANGE,
  parameter int COUNT_BITS  = DEF_COUNT_BITS
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  req_valid,
  output logic                  req_ready,
  input  req_item_t             req,
  output logic                  rsp_valid,
  input  logic                  rsp_ready,
  output rsp_item_t             rsp,
  input  logic                  cfg_we,
  input  logic [VALUE_BITS-1:0] cfg_wdata
);

  // only values below 1024 can ever be stored, so that bounds the search
  localparam int SR        = (VALUE_RANGE < MAX_SEARCH) ? VALUE_RANGE : MAX_SEARCH;
  localparam int CAW       = $clog2(SR);
  localparam int NW        = (SR + WORD_BITS - 1) / WORD_BITS;
  localparam int NWAW      = (NW > 1) ? $clog2(NW) : 1;
  localparam int LAST_BITS = SR - (NW - 1) * WORD_BITS;
  localparam logic [WORD_BITS-1:0] LAST_MASK =
    WORD_BITS'((64'd1 << LAST_BITS) - 64'd1);
  localparam logic [MEX_BITS-1:0]   MEX_NONE  = MEX_BITS'(SR);
  localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

  state_t state, state_next;

  logic [VALUE_BITS-1:0] mex_start;
  logic                  cur_kind;
  logic                  cur_inr;
  logic [CAW-1:0]        cur_ca;
  logic [NWAW-1:0]       cur_wi;
  logic [WORD_SHIFT-1:0] cur_off;
  logic                  res_acc;
  logic                  res_was;
  logic [NW-1:0]         word_vld;
  logic [NW-1:0]         full;
  logic                  fwd_en;
  logic [WORD_BITS-1:0]  fwd_word;
  logic [NWAW-1:0]       cand_w;
  logic                  rd_vld;

  logic                  p_we, p_re;
  logic [NWAW-1:0]       p_raddr;
  logic [WORD_BITS-1:0]  p_rdata;
  logic                  c_re;
  logic [COUNT_BITS-1:0] c_rdata;

  logic [NWAW-1:0]       req_wi;
  logic [CAW-1:0]        req_ca;
  logic [WORD_SHIFT-1:0] req_off;
  logic                  req_inr;
  logic [NWAW-1:0]       sw;
  logic [WORD_SHIFT-1:0] s_off;
  logic                  start_in;

  logic [WORD_BITS-1:0]  word_q;
  logic                  upd_was, upd_acc;
  logic [COUNT_BITS-1:0] cnt_old, cnt_new;
  logic [WORD_BITS-1:0]  new_word;

  logic [WORD_BITS-1:0]  sword, eff_a, eff_b;
  logic                  hit_a;
  logic [NW-1:0]         above;
  logic                  cand_ok;
  logic [NWAW-1:0]       cand_n;
  logic [MEX_BITS-1:0]   mex_a, mex_b, load_mex;
  logic                  done, load, out_free;

  function automatic logic [WORD_BITS-1:0] vmask(input logic [NWAW-1:0] w);
    return (int'(w) == NW - 1) ? LAST_MASK : '1;
  endfunction

  mmt_ram #(.DEPTH(NW), .WIDTH(WORD_BITS), .AW(NWAW)) u_presence (
    .clk   (clk),
    .we    (p_we),
    .waddr (cur_wi),
    .wdata (new_word),
    .re    (p_re),
    .raddr (p_raddr),
    .rdata (p_rdata)
  );

  mmt_ram #(.DEPTH(SR), .WIDTH(COUNT_BITS), .AW(CAW)) u_count (
    .clk   (clk),
    .we    (p_we),
    .waddr (cur_ca),
    .wdata (cnt_new),
    .re    (c_re),
    .raddr (req_ca),
    .rdata (c_rdata)
  );

  assign req_wi   = NWAW'(req.value >> WORD_SHIFT);
  assign req_ca   = CAW'(req.value);
  assign req_off  = req.value[WORD_SHIFT-1:0];
  assign req_inr  = int'(req.value) < VALUE_RANGE;
  assign sw       = NWAW'(mex_start >> WORD_SHIFT);
  assign s_off    = mex_start[WORD_SHIFT-1:0];
  assign start_in = int'(mex_start) < SR;

  assign req_ready = (state == ST_IDLE);
  assign out_free  = !rsp_valid || rsp_ready;
  assign c_re      = (state == ST_IDLE) && req_valid;

  // words never written read as all absent
  assign word_q = rd_vld ? p_rdata : '0;

  // read-modify-write of the count; presence bit qualifies stale count data
  always_comb begin
    upd_was = cur_inr & word_q[cur_off];
    cnt_old = upd_was ? c_rdata : '0;
    if (cur_kind == KIND_INSERT) begin
      upd_acc = cur_inr & (cnt_old != COUNT_MAX);
      cnt_new = cnt_old + COUNT_BITS'(1);
    end else begin
      upd_acc = upd_was;
      cnt_new = cnt_old - COUNT_BITS'(1);
    end
    new_word = word_q;
    if (upd_acc) new_word[cur_off] = (cnt_new != '0);
  end

  // start word: bits below mex_start and past the range count as present
  always_comb begin
    sword = fwd_en ? fwd_word : word_q;
    eff_a = sword | ~vmask(sw) | ((WORD_BITS'(1) << s_off) - WORD_BITS'(1));
    hit_a = ~&eff_a;
    for (int w = 0; w < NW; w++) begin
      above[w] = ~full[w] & (w > int'(sw));
    end
    cand_ok = |above;
    cand_n  = NWAW'(lowest_one(WORD_BITS'(above)));
    mex_a   = (MEX_BITS'(sw) << WORD_SHIFT) | MEX_BITS'(lowest_zero(eff_a));
    eff_b   = word_q | ~vmask(cand_w);
    mex_b   = (MEX_BITS'(cand_w) << WORD_SHIFT) | MEX_BITS'(lowest_zero(eff_b));
  end

  always_comb begin
    state_next = state;
    p_re       = 1'b0;
    p_we       = 1'b0;
    p_raddr    = req_wi;
    done       = 1'b0;
    load_mex   = MEX_NONE;
    unique case (state)
      ST_IDLE: begin
        if (req_valid) begin
          p_re       = 1'b1;
          state_next = ST_UPD;
        end
      end
      ST_UPD: begin
        p_we       = upd_acc;
        p_re       = 1'b1;
        p_raddr    = sw;
        state_next = ST_SRCH_A;
      end
      ST_SRCH_A: begin
        if (!start_in) begin
          done = 1'b1;
        end else if (hit_a) begin
          done     = 1'b1;
          load_mex = mex_a;
        end else if (cand_ok) begin
          p_re       = 1'b1;
          p_raddr    = cand_n;
          state_next = ST_SRCH_B;
        end else begin
          done = 1'b1;
        end
      end
      ST_SRCH_B: begin
        done     = 1'b1;
        load_mex = mex_b;
      end
      default: state_next = ST_IDLE;
    endcase
    load = done && out_free;
    if (load) state_next = ST_IDLE;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      mex_start <= '0;
      word_vld  <= '0;
      full      <= '0;
      rsp_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_we) mex_start <= cfg_wdata;
      if (p_we) begin
        word_vld[cur_wi] <= 1'b1;
        full[cur_wi]     <= &(new_word | ~vmask(cur_wi));
      end
      if (load) begin
        rsp_valid <= 1'b1;
      end else if (rsp_ready) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req_valid && req_ready) begin
      cur_kind <= req.kind;
      cur_inr  <= req_inr;
      cur_ca   <= req_ca;
      cur_wi   <= req_wi;
      cur_off  <= req_off;
    end
    if (p_re) rd_vld <= word_vld[p_raddr];
    if (state == ST_UPD) begin
      res_acc  <= upd_acc;
      res_was  <= upd_was;
      // start word may be the one written this cycle
      fwd_en   <= cur_inr && (sw == cur_wi);
      fwd_word <= new_word;
    end
    if (state == ST_SRCH_A && p_re) cand_w <= cand_n;
    if (load) begin
      rsp.accepted    <= res_acc;
      rsp.was_present <= res_was;
      rsp.mex_value   <= load_mex;
    end
  end

`ifndef ASSERT_OFF
  a_accept_to_upd: assert property (@(posedge clk) disable iff (rst)
    (req_valid && req_ready) |=> (state == ST_UPD))
    else $error("accepted item did not enter update");

  a_remove_needs_presence: assert property (@(posedge clk) disable iff (rst)
    (state == ST_UPD && cur_kind == KIND_REMOVE) |-> (upd_acc == upd_was))
    else $error("remove outcome disagrees with presence");

  a_out_of_range_ignored: assert property (@(posedge clk) disable iff (rst)
    (state == ST_UPD && !cur_inr) |-> (!upd_acc && !upd_was))
    else $error("out-of-range value changed state");

  a_mex_bound: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> (rsp.mex_value <= MEX_NONE))
    else $error("mex beyond search range");
`endif

endmodule
